### rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants of the box/frustum classifier
// Plane layout, box layout, visibility codes and datapath widths.
// ----------------------------------------------------------------------------
package afc_pkg;

   // frustum has six planes, boxes have three axes
   localparam int NUM_PLANES = 6;
   localparam int NUM_AXES   = 3;

   // field widths
   localparam int COORD_W = 18;
   localparam int NORM_W  = 12;
   localparam int OFFS_W  = 28;
   localparam int PLANE_W = 64;
   localparam int PROD_W  = NORM_W + COORD_W;
   localparam int DIST_W  = 33;
   localparam int VIS_W   = 2;

   // register index width for six planes
   localparam int CSR_IDX_W = $clog2(NUM_PLANES);

   // packed stream widths
   localparam int REQ_DATA_W = ((2 * NUM_AXES * COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VIS_W + 7) / 8) * 8;

   // outside margin, -0.01 in Q.10
   localparam logic signed [DIST_W-1:0] EPS_Q10 = -33'sd10;

   // classification result
   typedef enum logic [VIS_W-1:0] {
      VIS_OUTSIDE    = 2'd0,
      VIS_INSIDE     = 2'd1,
      VIS_INTERSECTS = 2'd2
   } vis_type;

   // one plane register: offset Q17.10 above nz, ny, nx in Q1.10
   typedef struct packed {
      logic signed [OFFS_W-1:0] offset;
      logic signed [NORM_W-1:0] nz;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nx;
   } plane_type;

   // sorted box, element 0 is x
   typedef struct packed {
      logic [NUM_AXES-1:0][COORD_W-1:0] hi;
      logic [NUM_AXES-1:0][COORD_W-1:0] lo;
   } box_type;

   // per-plane test outcome
   typedef struct packed {
      logic [NUM_PLANES-1:0] pos_below;
      logic [NUM_PLANES-1:0] neg_above;
   } plane_flags_type;

endpackage

### rtl/afc_sort.sv
// ----------------------------------------------------------------------------
// afc_sort: corner sorting stage
// Registers per-axis minimum and maximum of the two box corners.
// ----------------------------------------------------------------------------
module afc_sort (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic [afc_pkg::NUM_AXES-1:0][afc_pkg::COORD_W-1:0] corner_a,
   input  logic [afc_pkg::NUM_AXES-1:0][afc_pkg::COORD_W-1:0] corner_b,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output afc_pkg::box_type                                  box
);

   logic             valid_ff;
   logic             advance;
   afc_pkg::box_type box_ff;
   afc_pkg::box_type box_in;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   // per-axis compare and swap
   always_comb begin
      for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
         if ($signed(corner_a[a]) < $signed(corner_b[a])) begin
            box_in.lo[a] = corner_a[a];
            box_in.hi[a] = corner_b[a];
         end else begin
            box_in.lo[a] = corner_b[a];
            box_in.hi[a] = corner_a[a];
         end
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         box_ff <= box_in;
      end
   end

   assign out_valid = valid_ff;
   assign box       = box_ff;

endmodule

### rtl/afc_plane_eval.sv
// ----------------------------------------------------------------------------
// afc_plane_eval: plane distance stages
// Stage one picks p/n vertices and multiplies; stage two sums and compares.
// ----------------------------------------------------------------------------
module afc_plane_eval (
   input  logic                                    clock,
   input  logic                                    reset,
   input  afc_pkg::plane_type [afc_pkg::NUM_PLANES-1:0] planes,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  afc_pkg::box_type                        box,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output afc_pkg::plane_flags_type                flags
);

   localparam int NP = afc_pkg::NUM_PLANES;
   localparam int NA = afc_pkg::NUM_AXES;
   localparam int PW = afc_pkg::PROD_W;
   localparam int DW = afc_pkg::DIST_W;

   logic                    valid_a_ff;
   logic                    valid_b_ff;
   logic                    adv_a;
   logic                    adv_b;
   logic signed [afc_pkg::NORM_W-1:0]  norm    [NP][NA];
   logic signed [afc_pkg::COORD_W-1:0] pvert   [NP][NA];
   logic signed [afc_pkg::COORD_W-1:0] nvert   [NP][NA];
   logic signed [PW-1:0]    pos_prod_in  [NP][NA];
   logic signed [PW-1:0]    neg_prod_in  [NP][NA];
   logic signed [PW-1:0]    pos_prod_ff  [NP][NA];
   logic signed [PW-1:0]    neg_prod_ff  [NP][NA];
   logic signed [DW-1:0]    pos_dist [NP];
   logic signed [DW-1:0]    neg_dist [NP];
   afc_pkg::plane_flags_type flags_in;
   afc_pkg::plane_flags_type flags_ff;

   assign adv_b    = !valid_b_ff || out_ready;
   assign adv_a    = !valid_a_ff || adv_b;
   assign in_ready = adv_a;

   // vertex select by normal sign, then products
   always_comb begin
      for (int p = 0; p < NP; p++) begin
         norm[p][0] = planes[p].nx;
         norm[p][1] = planes[p].ny;
         norm[p][2] = planes[p].nz;
         for (int a = 0; a < NA; a++) begin
            if (norm[p][a][afc_pkg::NORM_W-1]) begin
               pvert[p][a] = $signed(box.lo[a]);
               nvert[p][a] = $signed(box.hi[a]);
            end else begin
               pvert[p][a] = $signed(box.hi[a]);
               nvert[p][a] = $signed(box.lo[a]);
            end
            pos_prod_in[p][a] = PW'(norm[p][a] * pvert[p][a]);
            neg_prod_in[p][a] = PW'(norm[p][a] * nvert[p][a]);
         end
      end
   end

   // sum of products plus offset, then threshold tests
   always_comb begin
      for (int p = 0; p < NP; p++) begin
         pos_dist[p] = DW'(planes[p].offset) + DW'(pos_prod_ff[p][0])
                     + DW'(pos_prod_ff[p][1]) + DW'(pos_prod_ff[p][2]);
         neg_dist[p] = DW'(planes[p].offset) + DW'(neg_prod_ff[p][0])
                     + DW'(neg_prod_ff[p][1]) + DW'(neg_prod_ff[p][2]);
         flags_in.pos_below[p] = pos_dist[p] < afc_pkg::EPS_Q10;
         flags_in.neg_above[p] = !neg_dist[p][DW-1];
      end
   end

   // valid bits of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            valid_a_ff <= in_valid;
         end
         if (adv_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   // product registers
   always_ff @(posedge clock) begin
      if (adv_a && in_valid) begin
         pos_prod_ff <= pos_prod_in;
         neg_prod_ff <= neg_prod_in;
      end
   end

   // flag registers
   always_ff @(posedge clock) begin
      if (adv_b && valid_a_ff) begin
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign flags     = flags_ff;

endmodule

### rtl/afc_decide.sv
// ----------------------------------------------------------------------------
// afc_decide: final classification stage
// Folds the per-plane flags into one visibility code and holds it for output.
// ----------------------------------------------------------------------------
module afc_decide (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  afc_pkg::plane_flags_type flags,
   output logic                     out_valid,
   input  logic                     out_ready,
   output afc_pkg::vis_type         visibility
);

   logic             valid_ff;
   logic             advance;
   afc_pkg::vis_type vis_ff;
   afc_pkg::vis_type vis_in;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   // any plane rejecting wins, then all planes accepting
   always_comb begin
      if (|flags.pos_below) begin
         vis_in = afc_pkg::VIS_OUTSIDE;
      end else if (&flags.neg_above) begin
         vis_in = afc_pkg::VIS_INSIDE;
      end else begin
         vis_in = afc_pkg::VIS_INTERSECTS;
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         vis_ff <= vis_in;
      end
   end

   assign out_valid  = valid_ff;
   assign visibility = vis_ff;

endmodule

### rtl/aabb_frustum_classifier.sv
// ----------------------------------------------------------------------------
// aabb_frustum_classifier: axis-aligned box against six frustum planes
//
// req channel: one word per box, two corners in any order, six signed
//   18-bit coordinates. rsp channel: one word per box, a 2-bit visibility
//   code (0 outside, 1 inside, 2 intersects), in input order.
// csr port: csr_we with csr_index 0..5 loads plane left, right, bottom, top,
//   near, far; other indexes are ignored. Write planes only while idle.
// Throughput: one box per cycle while rsp_tready is high. A box passes the
//   sort, multiply, sum/compare and decide registers in that order before its
//   word shows on rsp.
// Reset clears all planes (every box then reads inside) and empties the
//   pipeline. When rsp_tready is low the stages fill up behind the output
//   register and req_tready drops once every stage holds a word; nothing is
//   lost or repeated.
// ----------------------------------------------------------------------------
module aabb_frustum_classifier (
   input  logic                             clock,
   input  logic                             reset,
   // req
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z
   input  logic [afc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // visibility
   output logic [afc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // csr
   input  logic                             csr_we,
   input  logic [afc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [afc_pkg::PLANE_W-1:0]      csr_wdata
);

   localparam int NA = afc_pkg::NUM_AXES;
   localparam int CW = afc_pkg::COORD_W;

   afc_pkg::plane_type [afc_pkg::NUM_PLANES-1:0] plane_ff;
   logic [NA-1:0][CW-1:0]    corner_a;
   logic [NA-1:0][CW-1:0]    corner_b;
   afc_pkg::box_type         box;
   logic                     sort_valid;
   logic                     eval_ready;
   afc_pkg::plane_flags_type flags;
   logic                     eval_valid;
   logic                     decide_ready;
   afc_pkg::vis_type         visibility;

   // plane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (csr_we && (32'(csr_index) < afc_pkg::NUM_PLANES)) begin
         plane_ff[csr_index] <= afc_pkg::plane_type'(csr_wdata);
      end
   end

   // unpack the request word
   assign corner_a = req_tdata[NA*CW-1:0];
   assign corner_b = req_tdata[2*NA*CW-1:NA*CW];

   afc_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .corner_a  (corner_a),
      .corner_b  (corner_b),
      .out_valid (sort_valid),
      .out_ready (eval_ready),
      .box       (box)
   );

   afc_plane_eval u_plane_eval (
      .clock     (clock),
      .reset     (reset),
      .planes    (plane_ff),
      .in_valid  (sort_valid),
      .in_ready  (eval_ready),
      .box       (box),
      .out_valid (eval_valid),
      .out_ready (decide_ready),
      .flags     (flags)
   );

   afc_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (eval_valid),
      .in_ready   (decide_ready),
      .flags      (flags),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .visibility (visibility)
   );

   // pack the response word
   assign rsp_tdata = {{(afc_pkg::RSP_DATA_W - afc_pkg::VIS_W){1'b0}}, visibility};

endmodule

### dv/box_visibility_pkg.sv
// ----------------------------------------------------------------------------
// box_visibility_pkg: expected visibility of boxes against the frustum
// Keeps a copy of the six plane registers, works out the visibility of every
// box word taken by the classifier and checks the rsp words in order.
// ----------------------------------------------------------------------------
package box_visibility_pkg;

   import afc_pkg::*;

   typedef logic [REQ_DATA_W-1:0]    box_word_type;
   typedef logic [RSP_DATA_W-1:0]    vis_word_type;
   typedef logic [PLANE_W-1:0]       plane_word_type;
   typedef logic signed [COORD_W-1:0] coord_type;

   // a positive vertex more than 0.01 below a plane puts the box outside
   localparam longint OUTSIDE_MARGIN_Q10 = -10;

   class visibility_board;

      plane_type planes [NUM_PLANES];
      vis_type   expected_vis [$];
      int        failures;

      function new();
         failures = 0;
         foreach (planes[i]) planes[i] = '0;
      endfunction

      // indexes past the last plane are dropped by the block
      function void set_plane(int unsigned index, plane_word_type value);
         if (index < NUM_PLANES) planes[index] = value;
      endfunction

      function int pending();
         return expected_vis.size();
      endfunction

      // p-vertex / n-vertex test of one box against all planes
      function vis_type classify_box(box_word_type word);
         longint lo [NUM_AXES];
         longint hi [NUM_AXES];
         longint pos_dist;
         longint neg_dist;
         longint nrm_val;
         coord_type a;
         coord_type b;
         logic signed [NORM_W-1:0] nrm [NUM_AXES];
         int inside_cnt;
         inside_cnt = 0;
         // sort the corners per axis
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            a = word[ax*COORD_W +: COORD_W];
            b = word[(ax+NUM_AXES)*COORD_W +: COORD_W];
            lo[ax] = (a < b) ? a : b;
            hi[ax] = (a < b) ? b : a;
         end
         for (int p = 0; p < NUM_PLANES; p++) begin
            nrm[0] = planes[p].nx;
            nrm[1] = planes[p].ny;
            nrm[2] = planes[p].nz;
            pos_dist = $signed(planes[p].offset);
            neg_dist = pos_dist;
            // the sign of each normal component picks the vertex coordinate
            for (int ax = 0; ax < NUM_AXES; ax++) begin
               nrm_val = nrm[ax];
               if (nrm_val >= 0) begin
                  pos_dist += nrm_val * hi[ax];
                  neg_dist += nrm_val * lo[ax];
               end else begin
                  pos_dist += nrm_val * lo[ax];
                  neg_dist += nrm_val * hi[ax];
               end
            end
            if (pos_dist < OUTSIDE_MARGIN_Q10) return VIS_OUTSIDE;
            if (neg_dist >= 0) inside_cnt++;
         end
         return (inside_cnt == NUM_PLANES) ? VIS_INSIDE : VIS_INTERSECTS;
      endfunction

      // box word taken on req
      function void note_box(box_word_type word);
         expected_vis.push_back(classify_box(word));
      endfunction

      // visibility word taken on rsp, against the oldest expectation
      function void check_word(vis_word_type word);
         vis_type want;
         logic [VIS_W-1:0] got;
         got = word[VIS_W-1:0];
         if (expected_vis.size() == 0) begin
            $error("visibility: no result expected, actual %0d", got);
            failures++;
         end else begin
            want = expected_vis.pop_front();
            if (got !== want) begin
               $error("visibility: expected %0d, actual %0d", want, got);
               failures++;
            end
         end
      endfunction

   endclass

endpackage

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the box/frustum classifier
// Loads several plane sets (reset planes, extreme coefficients, planes that
// sit on the outside margin, random frustums, random register bits), streams
// directed and random boxes under varying idle and stall patterns, and checks
// every visibility word against a predictor of the p/n-vertex test.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import afc_pkg::*;
   import box_visibility_pkg::*;

   localparam int RESET_CYCLES     = 12;
   localparam int PIPE_LATENCY     = 4;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int PHASE_BOXES      = 115;

   // plane register indexes, then the two spare indexes past the last plane
   localparam logic [CSR_IDX_W-1:0] PLANE_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] PLANE_RIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] PLANE_BOTTOM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] PLANE_TOP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] PLANE_NEAR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] PLANE_FAR    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int COORD_MIN = -(2 ** (COORD_W - 1));
   localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
   localparam int NORM_MIN  = -(2 ** (NORM_W - 1));
   localparam int NORM_MAX  = 2 ** (NORM_W - 1) - 1;
   localparam int OFFS_MIN  = -(2 ** (OFFS_W - 1));
   localparam int OFFS_MAX  = 2 ** (OFFS_W - 1) - 1;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [PLANE_W-1:0]     csr_wdata  = '0;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;

   plane_word_type  plane_set [NUM_PLANES];
   visibility_board vis_board;

   aabb_frustum_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         hold_seen  = 0;
      end else if (hold_seen != hold_requests) begin
         hold_seen  = hold_requests;
         hold_left  = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // word monitor on both channels, rsp first since it is the older word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) vis_board.check_word(rsp_tdata);
         if (req_tvalid && req_tready) vis_board.note_box(req_tdata);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // one register write; the caller drops csr_we after the last one
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input plane_word_type value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      vis_board.set_plane(index, value);
   endtask

   task automatic load_planes();
      for (int p = 0; p < NUM_PLANES; p++) write_csr(CSR_IDX_W'(p), plane_set[p]);
      csr_we <= 1'b0;
   endtask

   function automatic plane_word_type plane_word(int nx, int ny, int nz, int offset);
      plane_type pl;
      pl.nx     = NORM_W'(nx);
      pl.ny     = NORM_W'(ny);
      pl.nz     = NORM_W'(nz);
      pl.offset = OFFS_W'(offset);
      return pl;
   endfunction

   function automatic box_word_type pack_corners(int a_x, int a_y, int a_z,
                                                 int b_x, int b_y, int b_z);
      box_word_type word;
      word = '0;
      word[0*COORD_W +: COORD_W] = COORD_W'(a_x);
      word[1*COORD_W +: COORD_W] = COORD_W'(a_y);
      word[2*COORD_W +: COORD_W] = COORD_W'(a_z);
      word[3*COORD_W +: COORD_W] = COORD_W'(b_x);
      word[4*COORD_W +: COORD_W] = COORD_W'(b_y);
      word[5*COORD_W +: COORD_W] = COORD_W'(b_z);
      return word;
   endfunction

   // box around a random center; some full-range corners and some points
   function automatic box_word_type make_box(int span, int extent, int full_pct);
      box_word_type word;
      int ctr;
      int half;
      int roll;
      word = '0;
      roll = $urandom_range(99);
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         if (roll < full_pct) begin
            word[ax*COORD_W +: COORD_W]            = COORD_W'($urandom);
            word[(ax+NUM_AXES)*COORD_W +: COORD_W] = COORD_W'($urandom);
         end else begin
            ctr  = int'($urandom_range(2 * span)) - span;
            half = (roll < full_pct + 5) ? 0 : int'($urandom_range(extent));
            if ($urandom_range(1)) half = -half;
            word[ax*COORD_W +: COORD_W]            = COORD_W'(ctr - half);
            word[(ax+NUM_AXES)*COORD_W +: COORD_W] = COORD_W'(ctr + half);
         end
      end
      return word;
   endfunction

   // box-shaped frustum of half size half_len with tilted planes
   task automatic load_frustum(int half_len, int tilt);
      plane_type pl;
      int main_n;
      for (int p = 0; p < NUM_PLANES; p++) begin
         main_n    = $urandom_range(1024, 512);
         pl.nx     = NORM_W'(int'($urandom_range(2 * tilt)) - tilt);
         pl.ny     = NORM_W'(int'($urandom_range(2 * tilt)) - tilt);
         pl.nz     = NORM_W'(int'($urandom_range(2 * tilt)) - tilt);
         pl.offset = OFFS_W'(half_len * main_n + int'($urandom_range(2 * half_len)) - half_len);
         case (p / 2)
            0: pl.nx = NORM_W'((p % 2 == 0) ? main_n : -main_n);
            1: pl.ny = NORM_W'((p % 2 == 0) ? main_n : -main_n);
            default: pl.nz = NORM_W'((p % 2 == 0) ? main_n : -main_n);
         endcase
         plane_set[p] = pl;
      end
      load_planes();
   endtask

   task automatic send_box(input box_word_type word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop offering and wait for every expected word, then the pipe depth
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (vis_board.pending() != 0);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   task automatic run_boxes(int count, int span, int extent, int full_pct, bit pause_midway);
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) drain_pipeline();
         send_box(make_box(span, extent, full_pct));
      end
      drain_pipeline();
   endtask

   task automatic random_frustum_phase(bit pause_midway);
      int half_len;
      half_len = ($urandom_range(3) == 0) ? $urandom_range(200, 20) : $urandom_range(60000, 200);
      load_frustum(half_len, $urandom_range(300));
      run_boxes(PHASE_BOXES, half_len + half_len / 2, half_len / 4 + 1, 5, pause_midway);
   endtask

   initial begin
      vis_board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // writes past the last plane must leave the planes at zero
      write_csr(CSR_SPARE_LO, {$urandom, $urandom});
      write_csr(CSR_SPARE_HI, '1);
      csr_we <= 1'b0;

      // all-zero planes: every box is inside
      send_box(pack_corners(0, 0, 0, 0, 0, 0));
      send_box(pack_corners(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(pack_corners(COORD_MAX, 5, COORD_MIN, -7, COORD_MIN, COORD_MAX));
      send_box(pack_corners(123, -456, 789, 123, -456, 789));
      drain_pipeline();

      // extreme coefficients and extreme corners
      plane_set[PLANE_LEFT]   = '1;
      plane_set[PLANE_RIGHT]  = plane_word(NORM_MIN, NORM_MIN, NORM_MIN, OFFS_MAX);
      plane_set[PLANE_BOTTOM] = plane_word(NORM_MAX, NORM_MAX, NORM_MAX, OFFS_MIN);
      plane_set[PLANE_TOP]    = plane_word(NORM_MIN, NORM_MAX, NORM_MIN, 0);
      plane_set[PLANE_NEAR]   = plane_word(NORM_MAX, NORM_MIN, NORM_MAX, 12345);
      plane_set[PLANE_FAR]    = '0;
      load_planes();
      send_box(pack_corners(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_box(pack_corners(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(pack_corners(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(pack_corners(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
      send_box(pack_corners(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
      send_box(pack_corners(0, 0, 0, 0, 0, 0));
      drain_pipeline();

      // planes x >= 0 and x <= 100 at the smallest normal: margin edges
      plane_set[PLANE_LEFT]   = plane_word(1, 0, 0, 0);
      plane_set[PLANE_RIGHT]  = plane_word(-1, 0, 0, 100);
      plane_set[PLANE_BOTTOM] = '0;
      plane_set[PLANE_TOP]    = '0;
      plane_set[PLANE_NEAR]   = '0;
      plane_set[PLANE_FAR]    = '0;
      load_planes();
      send_box(pack_corners(0, 0, 0, 0, 0, 0));
      send_box(pack_corners(-1, 0, 0, -1, 0, 0));
      send_box(pack_corners(-10, 3, 3, -10, 3, 3));
      send_box(pack_corners(-11, 3, 3, -11, 3, 3));
      send_box(pack_corners(100, 0, 0, 100, 0, 0));
      send_box(pack_corners(110, -9, 9, 110, -9, 9));
      send_box(pack_corners(111, 0, 0, 111, 0, 0));
      send_box(pack_corners(-11, 0, 0, 111, 0, 0));
      send_box(pack_corners(111, 0, 0, -11, 0, 0));
      drain_pipeline();

      // random frustums, no idling
      random_frustum_phase(1'b0);

      // sparse sender
      send_idle_pct = 82;
      random_frustum_phase(1'b0);

      // slow receiver
      send_idle_pct = 0;
      stall_pct    <= 82;
      random_frustum_phase(1'b0);

      // light idling on both sides
      send_idle_pct = 8;
      stall_pct    <= 8;
      random_frustum_phase(1'b0);

      // long hold-off to back up the pipe, then a pause until drained
      send_idle_pct  = 0;
      stall_pct     <= 0;
      hold_requests <= hold_requests + 1;
      random_frustum_phase(1'b1);

      // random register bits with mostly full-range corners
      send_idle_pct = 8;
      stall_pct    <= 8;
      for (int p = 0; p < NUM_PLANES; p++) plane_set[p] = {$urandom, $urandom};
      load_planes();
      run_boxes(PHASE_BOXES, 2000, 500, 60, 1'b0);

      if (vis_board.failures == 0 && vis_board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/afc_pkg.sv
rtl/afc_sort.sv
rtl/afc_plane_eval.sv
rtl/afc_decide.sv
rtl/aabb_frustum_classifier.sv
dv/box_visibility_pkg.sv
dv/tb_top.sv
